[rtl/tmse_pkg.sv]
// Shared types and constants for the Turing machine step engine.
package tmse_pkg;

    localparam logic [6:0] SYM_A = 7'd65;
    localparam logic [6:0] SYM_B = 7'd66;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_APPEND = 3'd1,
        OP_START  = 3'd2,
        OP_STEP   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_LEFT_EDGE = 2'd1,
        STAT_TAPE_FULL = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    localparam logic [1:0] CFG_START_STATE = 2'd0;
    localparam logic [1:0] CFG_HALT_STATE  = 2'd1;

    typedef struct packed {
        logic [6:0] wsym;
        logic       right;
        logic [3:0] nxt;
    } rule_t;

    localparam rule_t RULE_DEFAULT = '{wsym: SYM_B, right: 1'b1, nxt: 4'd0};

    typedef struct packed {
        logic       wr_en;
        logic [6:0] sym;
        logic [3:0] state;
        rule_t      entry;
    } rule_cmd_t;

    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_EXEC,
        FSM_LOOKUP,
        FSM_APPLY,
        FSM_EXTEND,
        FSM_FETCH,
        FSM_REPLY
    } fsm_t;

endpackage

[rtl/turing_machine_step_engine_core.sv]
// Top level of the Turing machine step engine: tape memory, control and result port.
//
//   Channel   Handshake            Accepted when            Carries
//   command   start / busy         start && !busy           op, symbol, rule and position fields
//   result    done strobe          every cycle done is high current_state .. tape_length
//   config    cfg_valid/cfg_ready  cfg_valid && cfg_ready   cfg_index, cfg_data
//
// A step passes through EXEC, LOOKUP, APPLY, FETCH and REPLY, with EXTEND after APPLY when it
// extends the tape; a step at the halt state and every other command go from EXEC to FETCH.
// The step cost is the chain tape read, rule read, tape write and a re-read of the cell under
// the new head on the single tape read port.
// After reset the rule table is swept to its reset value with busy high; configuration
// writes are taken throughout. Results cannot be stalled.
module turing_machine_step_engine_core
    import tmse_pkg::*;
#(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 128,
    parameter int TAPE_CELLS   = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [6:0]  symbol,
    input  logic [3:0]  rule_state,
    input  logic [6:0]  write_symbol,
    input  logic        move_right,
    input  logic [3:0]  rule_next,
    input  logic [9:0]  position,
    output logic        done,
    output logic [3:0]  current_state,
    output logic [9:0]  head_position,
    output logic [6:0]  cell_symbol,
    output logic        halted,
    output logic [1:0]  status,
    output logic [10:0] tape_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int HW  = $clog2(TAPE_CELLS);
    localparam int LW  = $clog2(TAPE_CELLS + 1);
    localparam int PCW = (LW > 10) ? LW : 10;

    fsm_t            state_reg, state_next;

    logic [2:0]      op_reg;
    logic [6:0]      sym_reg;
    logic [3:0]      rstate_reg;
    logic [6:0]      wsym_reg;
    logic            mright_reg;
    logic [3:0]      rnext_reg;
    logic [9:0]      pos_reg;
    logic [1:0]      status_reg;
    logic            pos_ok_reg;

    logic [3:0]      start_state_reg;
    logic [3:0]      halt_state_reg;
    logic [HW-1:0]   head_reg;
    logic [3:0]      mstate_reg;
    logic [LW-1:0]   used_reg;
    logic            cell0_reg;
    logic            done_reg;

    logic [3:0]      out_state_reg;
    logic [9:0]      out_head_reg;
    logic [6:0]      out_cell_reg;
    logic            out_halted_reg;
    logic [1:0]      out_status_reg;
    logic [10:0]     out_length_reg;

    logic [6:0]      tape_mem [TAPE_CELLS];
    logic [6:0]      tape_rdata_reg;
    logic            tape_a_reg;
    logic            tape_we;
    logic [HW-1:0]   tape_waddr;
    logic [6:0]      tape_wdata;
    logic [HW-1:0]   tape_raddr;

    rule_cmd_t       rule_cmd;
    logic            rule_ready;
    logic            rule_in_range;
    rule_t           rule_rd;

    logic            accept;
    logic [6:0]      under_sym;
    logic            tape_room;
    logic            pos_ok;
    logic            at_end;
    logic            extend;

    tmse_rule_table #(
        .STATE_COUNT  (STATE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_rules (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rule_cmd),
        .ready    (rule_ready),
        .in_range (rule_in_range),
        .rd_entry (rule_rd)
    );

    assign busy      = (state_reg != FSM_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Cell 0 reads as 'A' until it is first written; every other cell is written before use.
    assign under_sym = tape_a_reg ? SYM_A : tape_rdata_reg;
    assign tape_room = (used_reg < LW'(TAPE_CELLS));
    assign pos_ok    = (PCW'(pos_reg) < PCW'(used_reg));
    assign at_end    = (head_reg == HW'(TAPE_CELLS - 1));
    assign extend    = rule_rd.right && !at_end && ((LW'(head_reg) + LW'(1)) >= used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tape_we        = 1'b0;
        tape_waddr     = head_reg;
        tape_wdata     = SYM_B;
        tape_raddr     = head_reg;
        rule_cmd.wr_en = 1'b0;
        rule_cmd.sym   = sym_reg;
        rule_cmd.state = rstate_reg;
        rule_cmd.entry = '{wsym: wsym_reg, right: mright_reg, nxt: rnext_reg};
        unique case (state_reg)
            FSM_INIT:
            begin
                if (rule_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_FETCH;
                case (op_reg)
                    OP_LOAD:
                    begin
                        rule_cmd.wr_en = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        tape_we    = tape_room;
                        tape_waddr = HW'(used_reg);
                        tape_wdata = sym_reg;
                    end
                    OP_STEP:
                    begin
                        if (mstate_reg != halt_state_reg)
                        begin
                            state_next = FSM_LOOKUP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FSM_LOOKUP:
            begin
                rule_cmd.sym   = under_sym;
                rule_cmd.state = mstate_reg;
                state_next     = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                tape_we    = 1'b1;
                tape_wdata = rule_rd.wsym;
                state_next = extend ? FSM_EXTEND : FSM_FETCH;
            end
            FSM_EXTEND:
            begin
                tape_we    = 1'b1;
                state_next = FSM_FETCH;
            end
            FSM_FETCH:
            begin
                if (op_reg == OP_READ)
                begin
                    tape_raddr = HW'(pos_reg);
                end
                state_next = FSM_REPLY;
            end
            FSM_REPLY:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[tape_raddr];
        tape_a_reg     <= (tape_raddr == '0) && !cell0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            halt_state_reg  <= '0;
            head_reg        <= '0;
            mstate_reg      <= '0;
            used_reg        <= LW'(1);
            cell0_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == FSM_REPLY);
            if (tape_we && (tape_waddr == '0))
            begin
                cell0_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_START_STATE: start_state_reg <= cfg_data;
                    CFG_HALT_STATE:  halt_state_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == FSM_EXEC)
            begin
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (tape_room)
                        begin
                            used_reg <= used_reg + 1'b1;
                        end
                    end
                    OP_START:
                    begin
                        head_reg   <= '0;
                        mstate_reg <= start_state_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == FSM_APPLY)
            begin
                mstate_reg <= rule_rd.nxt;
                if (rule_rd.right)
                begin
                    if (!at_end)
                    begin
                        head_reg <= head_reg + 1'b1;
                        if (extend)
                        begin
                            used_reg <= LW'(head_reg) + LW'(2);
                        end
                    end
                end
                else if (head_reg != '0)
                begin
                    head_reg <= head_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            sym_reg    <= symbol;
            rstate_reg <= rule_state;
            wsym_reg   <= write_symbol;
            mright_reg <= move_right;
            rnext_reg  <= rule_next;
            pos_reg    <= position;
            status_reg <= STAT_OK;
        end
        if (state_reg == FSM_EXEC)
        begin
            pos_ok_reg <= pos_ok;
            case (op_reg)
                OP_LOAD:
                begin
                    if (!rule_in_range)
                    begin
                        status_reg <= STAT_RANGE;
                    end
                end
                OP_APPEND:
                begin
                    if (!tape_room)
                    begin
                        status_reg <= STAT_TAPE_FULL;
                    end
                end
                OP_READ:
                begin
                    if (!pos_ok)
                    begin
                        status_reg <= STAT_RANGE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == FSM_APPLY)
        begin
            if (rule_rd.right && at_end)
            begin
                status_reg <= STAT_TAPE_FULL;
            end
            else if (!rule_rd.right && (head_reg == '0))
            begin
                status_reg <= STAT_LEFT_EDGE;
            end
        end
        if (state_reg == FSM_REPLY)
        begin
            out_state_reg  <= mstate_reg;
            out_head_reg   <= 10'(head_reg);
            out_cell_reg   <= ((op_reg == OP_READ) && !pos_ok_reg) ? 7'd0 : under_sym;
            out_halted_reg <= (mstate_reg == halt_state_reg);
            out_status_reg <= status_reg;
            out_length_reg <= 11'(used_reg);
        end
    end

    assign done          = done_reg;
    assign current_state = out_state_reg;
    assign head_position = out_head_reg;
    assign cell_symbol   = out_cell_reg;
    assign halted        = out_halted_reg;
    assign status        = out_status_reg;
    assign tape_length   = out_length_reg;

endmodule

[rtl/tmse_rule_table.sv]
// Rule table memory with its clearing pass after reset and index range check.
module tmse_rule_table
    import tmse_pkg::*;
#(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rule_cmd_t cmd,
    output logic      ready,
    output logic      in_range,
    output rule_t     rd_entry
);

    localparam int RULE_SLOTS = STATE_COUNT * SYMBOL_COUNT;
    localparam int AW         = $clog2(RULE_SLOTS);

    rule_t          mem [RULE_SLOTS];
    logic [AW-1:0]  idx;
    logic [AW-1:0]  clr_reg;
    logic           clearing_reg;
    rule_t          rd_reg;
    logic           hit_reg;

    assign in_range = (9'(cmd.sym) < 9'(SYMBOL_COUNT)) && (9'(cmd.state) < 9'(STATE_COUNT));
    assign idx      = AW'(cmd.sym) * AW'(STATE_COUNT) + AW'(cmd.state);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(RULE_SLOTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // A lookup outside the table answers with the reset rule.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_reg] <= RULE_DEFAULT;
        end
        else if (cmd.wr_en && in_range)
        begin
            mem[idx] <= cmd.entry;
        end
        rd_reg  <= mem[idx];
        hit_reg <= in_range;
    end

    assign ready    = !clearing_reg;
    assign rd_entry = hit_reg ? rd_reg : RULE_DEFAULT;

endmodule
